/* rtl/core/fixed_point_decimal_formatter_core_assert.svh */
// assertion macros for the decimal formatter core
`ifndef FIXED_POINT_DECIMAL_FORMATTER_CORE_ASSERT_SVH
`define FIXED_POINT_DECIMAL_FORMATTER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define FPDF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define FPDF_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) pre |=> post) else $error(msg);
`else
`define FPDF_ASSERT(lbl, prop, msg)
`define FPDF_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

/* rtl/core/fpdf_pkg.sv */
`timescale 1ns / 1ps
package fpdf_pkg;

  // register indexes
  localparam int unsigned CfgIndexW = 3;
  typedef enum logic [CfgIndexW-1:0] {
    CFG_SCALE     = 3'd0,
    CFG_PRECISION = 3'd1,
    CFG_GROUP_EN  = 3'd2,
    CFG_SEP_CHAR  = 3'd3,
    CFG_POINT     = 3'd4,
    CFG_FIRST     = 3'd5,
    CFG_LATER     = 3'd6
  } cfg_idx_e;

  // reset values
  localparam logic [5:0] RST_SCALE     = 6'd30;
  localparam logic [5:0] RST_PRECISION = 6'd2;
  localparam logic       RST_GROUP_EN  = 1'b1;
  localparam logic [7:0] RST_SEP_CHAR  = 8'd44;
  localparam logic [7:0] RST_POINT     = 8'd46;
  localparam logic [3:0] RST_FIRST     = 4'd3;
  localparam logic [3:0] RST_LATER     = 4'd3;

  localparam logic [3:0] GROUP_MIN = 4'd2;
  localparam logic [3:0] GROUP_MAX = 4'd9;

  // character codes
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_ONE   = 8'h31;
  localparam logic [7:0] CHAR_LESS  = 8'h3c;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  typedef struct packed {
    logic [5:0] scale_exponent;
    logic [5:0] precision;
    logic       group_enable;
    logic [7:0] separator_char;
    logic [7:0] point_char;
    logic [3:0] first_group_size;
    logic [3:0] later_group_size;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CONV, ST_SCAN, ST_DECIDE, ST_INT, ST_SEP, ST_POINT, ST_FRAC, ST_LT
  } state_e;

  typedef enum logic [1:0] {
    CH_DIGIT, CH_SEP, CH_POINT, CH_LT
  } char_sel_e;

  typedef struct packed {
    logic      load;
    logic      conv;
    logic      prep;
    logic      scan;
    logic      shift;
    logic      started_set;
    logic      fcnt_inc;
    logic      emit;
    char_sel_e sel;
    logic      last;
  } cmd_t;

  typedef struct packed {
    logic conv_done;
    logic scan_done;
    logic pos_gt_e;
    logic pos_eq_e;
    logic top_nz;
    logic started;
    logic sep_here;
    logic frac_show;
    logic lt;
    logic rest_nz;
    logic frac_last;
    logic lt_last;
    logic out_free;
  } status_t;

endpackage

/* rtl/core/fpdf_if.sv */
`timescale 1ns / 1ps
interface fpdf_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] amount_high;
  logic [63:0] amount_low;
  modport source (output valid, amount_high, amount_low, input ready);
  modport sink (input valid, amount_high, amount_low, output ready);
endinterface

interface fpdf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       last_char;
  modport source (output valid, text_char, last_char, input ready);
  modport sink (input valid, text_char, last_char, output ready);
endinterface

/* rtl/core/fpdf_datapath.sv */
`timescale 1ns / 1ps
module fpdf_datapath #(
  parameter int unsigned AMOUNT_WIDTH = 128,
  parameter int unsigned MAX_DIGITS   = 39
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  fpdf_pkg::cfg_t   cfg_i,
  input  logic [63:0]      amount_high_i,
  input  logic [63:0]      amount_low_i,
  input  fpdf_pkg::cmd_t   cmd_i,
  output fpdf_pkg::status_t status_o,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic [7:0]       text_char_o,
  output logic             last_char_o
);
  import fpdf_pkg::*;

  localparam int unsigned BW = 4 * MAX_DIGITS;
  localparam int unsigned CW = $clog2(AMOUNT_WIDTH + 1);
  localparam int unsigned PW = $clog2(MAX_DIGITS + 1);
  localparam int unsigned IW = $clog2(MAX_DIGITS);
  localparam logic [5:0] EMAX = 6'(MAX_DIGITS - 1);
  localparam logic [PW-1:0] POS_TOP = PW'(MAX_DIGITS - 1);
  localparam logic [PW-1:0] POS_END = PW'(MAX_DIGITS);

  logic [AMOUNT_WIDTH-1:0] bin_q, bin_d;
  logic [BW-1:0]           bcd_q, bcd_d, bcd_adj;
  logic [CW-1:0]           cnt_q, cnt_d;
  logic [PW-1:0]           pos_q, pos_d;
  logic [MAX_DIGITS-1:0]   sep_q, sep_d;
  logic [3:0]              dist_q, dist_d;
  logic                    frac_nz_q, frac_nz_d, shown_nz_q, shown_nz_d;
  logic                    int_nz_q, int_nz_d, started_q, started_d;
  logic [6:0]              fcnt_q, fcnt_d;
  logic                    valid_q, valid_d, last_q, last_d;
  logic [7:0]              char_q, char_d;

  logic [5:0] e_w, p_w;
  logic [3:0] f_w, l_w;
  logic [6:0] e_x, p_x, pos_x;
  logic [3:0] top;
  logic       grouping;
  logic [7:0] lt_char;
  logic [127:0] amount;

  // effective settings
  always_comb begin
    e_w = (cfg_i.scale_exponent > EMAX) ? EMAX : cfg_i.scale_exponent;
    p_w = (cfg_i.precision > e_w) ? e_w : cfg_i.precision;
    f_w = (cfg_i.first_group_size < GROUP_MIN) ? GROUP_MIN :
          (cfg_i.first_group_size > GROUP_MAX) ? GROUP_MAX : cfg_i.first_group_size;
    l_w = (cfg_i.later_group_size < GROUP_MIN) ? GROUP_MIN :
          (cfg_i.later_group_size > GROUP_MAX) ? GROUP_MAX : cfg_i.later_group_size;
    grouping = cfg_i.group_enable && (cfg_i.separator_char != 8'd0);
  end

  assign e_x    = {1'b0, e_w};
  assign p_x    = {1'b0, p_w};
  assign pos_x  = 7'(pos_q);
  assign top    = bcd_q[BW-1 -: 4];
  assign amount = {amount_high_i, amount_low_i};

  // double dabble add-3 correction, one per digit
  always_comb begin
    for (int j = 0; j < MAX_DIGITS; j++) begin
      bcd_adj[4*j +: 4] = (bcd_q[4*j +: 4] >= 4'd5) ? bcd_q[4*j +: 4] + 4'd3
                                                    : bcd_q[4*j +: 4];
    end
  end

  // less-than text sequence
  always_comb begin
    if (fcnt_q == 7'd0) begin
      lt_char = CHAR_LESS;
    end else if (fcnt_q == 7'd1) begin
      lt_char = CHAR_SPACE;
    end else if (p_w == 6'd0) begin
      lt_char = CHAR_ONE;
    end else if (fcnt_q == 7'd3) begin
      lt_char = cfg_i.point_char;
    end else if (fcnt_q == p_x + 7'd3) begin
      lt_char = CHAR_ONE;
    end else begin
      lt_char = CHAR_ZERO;
    end
  end

  // next state of the datapath registers
  always_comb begin
    bin_d      = bin_q;
    bcd_d      = bcd_q;
    cnt_d      = cnt_q;
    pos_d      = pos_q;
    sep_d      = sep_q;
    dist_d     = dist_q;
    frac_nz_d  = frac_nz_q;
    shown_nz_d = shown_nz_q;
    int_nz_d   = int_nz_q;
    started_d  = started_q;
    fcnt_d     = fcnt_q;
    if (cmd_i.load) begin
      bin_d = amount[AMOUNT_WIDTH-1:0];
      bcd_d = '0;
      cnt_d = CW'(AMOUNT_WIDTH);
      pos_d = '0;
      sep_d = '0;
      dist_d = '0;
    end
    if (cmd_i.conv) begin
      bcd_d = {bcd_adj[BW-2:0], bin_q[AMOUNT_WIDTH-1]};
      bin_d = {bin_q[AMOUNT_WIDTH-2:0], 1'b0};
      cnt_d = cnt_q - CW'(1);
      // separator positions, built upward from the units digit
      if (pos_q != POS_END) begin
        if (pos_x == e_x) begin
          dist_d = f_w;
        end else if (pos_x > e_x) begin
          if (dist_q == 4'd1) begin
            sep_d[pos_q[IW-1:0]] = 1'b1;
            dist_d = l_w;
          end else begin
            dist_d = dist_q - 4'd1;
          end
        end
        pos_d = pos_q + PW'(1);
      end
    end
    if (cmd_i.prep) begin
      pos_d      = POS_TOP;
      frac_nz_d  = 1'b0;
      shown_nz_d = 1'b0;
      int_nz_d   = 1'b0;
      started_d  = 1'b0;
      fcnt_d     = '0;
    end
    if (cmd_i.scan) begin
      if (top != 4'd0) begin
        if (pos_x < e_x) begin
          frac_nz_d = 1'b1;
          if (pos_x + p_x >= e_x) shown_nz_d = 1'b1;
        end else begin
          int_nz_d = 1'b1;
        end
      end
      bcd_d = {bcd_q[BW-5:0], top};
      pos_d = (pos_q == '0) ? POS_TOP : pos_q - PW'(1);
    end
    if (cmd_i.shift) begin
      bcd_d = {bcd_q[BW-5:0], 4'd0};
      sep_d = {sep_q[MAX_DIGITS-2:0], 1'b0};
      pos_d = pos_q - PW'(1);
    end
    if (cmd_i.started_set) started_d = 1'b1;
    if (cmd_i.fcnt_inc) fcnt_d = fcnt_q + 7'd1;
  end

  // output register
  always_comb begin
    valid_d = valid_q;
    char_d  = char_q;
    last_d  = last_q;
    if (cmd_i.emit) begin
      valid_d = 1'b1;
      last_d  = cmd_i.last;
      unique case (cmd_i.sel)
        CH_DIGIT: char_d = CHAR_ZERO | {4'd0, top};
        CH_SEP:   char_d = cfg_i.separator_char;
        CH_POINT: char_d = cfg_i.point_char;
        CH_LT:    char_d = lt_char;
        default:  char_d = CHAR_ZERO;
      endcase
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= '0;
      pos_q   <= '0;
    end else begin
      valid_q <= valid_d;
      cnt_q   <= cnt_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q      <= bin_d;
    bcd_q      <= bcd_d;
    sep_q      <= sep_d;
    dist_q     <= dist_d;
    frac_nz_q  <= frac_nz_d;
    shown_nz_q <= shown_nz_d;
    int_nz_q   <= int_nz_d;
    started_q  <= started_d;
    fcnt_q     <= fcnt_d;
    char_q     <= char_d;
    last_q     <= last_d;
  end

  // status to the controller
  always_comb begin
    status_o.conv_done = (cnt_q == '0);
    status_o.scan_done = (pos_q == '0);
    status_o.pos_gt_e  = (pos_x > e_x);
    status_o.pos_eq_e  = (pos_x == e_x);
    status_o.top_nz    = (top != 4'd0);
    status_o.started   = started_q;
    status_o.sep_here  = grouping && sep_q[MAX_DIGITS-1];
    status_o.frac_show = (p_w != 6'd0) && frac_nz_q;
    status_o.lt        = !int_nz_q && frac_nz_q && !shown_nz_q;
    status_o.rest_nz   = |bcd_q[BW-5:0];
    status_o.frac_last = (fcnt_q + 7'd1 == p_x);
    status_o.lt_last   = ((p_w == 6'd0) && (fcnt_q == 7'd2)) ||
                         ((p_w != 6'd0) && (fcnt_q == p_x + 7'd3));
    status_o.out_free  = !valid_q || out_ready_i;
  end

  assign out_valid_o = valid_q;
  assign text_char_o = char_q;
  assign last_char_o = last_q;

endmodule

/* rtl/core/fpdf_ctrl.sv */
`timescale 1ns / 1ps
`include "fixed_point_decimal_formatter_core_assert.svh"
module fpdf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  fpdf_pkg::status_t status_i,
  output fpdf_pkg::cmd_t    cmd_o
);
  import fpdf_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.sel  = CH_DIGIT;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = ST_CONV;
        end
      end
      ST_CONV: begin
        if (status_i.conv_done) begin
          cmd_o.prep = 1'b1;
          state_d = ST_SCAN;
        end else begin
          cmd_o.conv = 1'b1;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.scan_done) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_d = status_i.lt ? ST_LT : ST_INT;
      end
      ST_INT: begin
        // skip leading zeros above the units digit
        if (status_i.pos_gt_e && !status_i.top_nz && !status_i.started) begin
          cmd_o.shift = 1'b1;
        end else if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel = CH_DIGIT;
          cmd_o.shift = 1'b1;
          cmd_o.started_set = 1'b1;
          cmd_o.last = status_i.pos_eq_e && !status_i.frac_show;
          if (status_i.sep_here && status_i.pos_gt_e) begin
            state_d = ST_SEP;
          end else if (status_i.pos_eq_e) begin
            state_d = status_i.frac_show ? ST_POINT : ST_IDLE;
          end
        end
      end
      ST_SEP: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel = CH_SEP;
          state_d = ST_INT;
        end
      end
      ST_POINT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel = CH_POINT;
          state_d = ST_FRAC;
        end
      end
      ST_FRAC: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel = CH_DIGIT;
          cmd_o.shift = 1'b1;
          cmd_o.fcnt_inc = 1'b1;
          cmd_o.last = status_i.frac_last || !status_i.rest_nz;
          if (cmd_o.last) state_d = ST_IDLE;
        end
      end
      ST_LT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel = CH_LT;
          cmd_o.fcnt_inc = 1'b1;
          cmd_o.last = status_i.lt_last;
          if (status_i.lt_last) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  `FPDF_ASSERT(a_emit_free, cmd_o.emit |-> status_i.out_free, "beat emitted into full slot")
  `FPDF_ASSERT_NEXT(a_load_conv, state_q == ST_IDLE && in_valid_i, state_q == ST_CONV, "no conversion after accept")
  `FPDF_ASSERT_NEXT(a_sep_back, state_q == ST_SEP && status_i.out_free, state_q == ST_INT, "separator did not return to digits")

endmodule

/* rtl/core/fixed_point_decimal_formatter_core.sv */
`timescale 1ns / 1ps
// channel  | dir | payload                      | handshake
// in_if    | in  | amount_high, amount_low      | valid / ready
// out_if   | out | text_char, last_char         | valid / ready
// cfg      | in  | cfg_index_i, cfg_data_i      | cfg_we_i, no wait
// one amount goes through shift-and-add-3 conversion, then a scan of the digits
// that picks the text form, then leading zeros above the units digit are skipped
// and the characters are sent, one character per output beat.
// one amount at a time; the next is taken once the last beat sits in the
// output register. output stalls hold the sequencer. reset clears the
// registers to their listed values and the pipeline to idle.
module fixed_point_decimal_formatter_core #(
  parameter int unsigned AMOUNT_WIDTH = 128,
  parameter int unsigned MAX_DIGITS   = 39
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  fpdf_in_if.sink                        in_if,
  fpdf_out_if.source                     out_if,
  input  logic                           cfg_we_i,
  input  logic [fpdf_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [7:0]                     cfg_data_i
);
  import fpdf_pkg::*;

  cfg_t    cfg_q;
  cmd_t    cmd;
  status_t status;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scale_exponent   <= RST_SCALE;
      cfg_q.precision        <= RST_PRECISION;
      cfg_q.group_enable     <= RST_GROUP_EN;
      cfg_q.separator_char   <= RST_SEP_CHAR;
      cfg_q.point_char       <= RST_POINT;
      cfg_q.first_group_size <= RST_FIRST;
      cfg_q.later_group_size <= RST_LATER;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SCALE:     cfg_q.scale_exponent   <= cfg_data_i[5:0];
        CFG_PRECISION: cfg_q.precision        <= cfg_data_i[5:0];
        CFG_GROUP_EN:  cfg_q.group_enable     <= cfg_data_i[0];
        CFG_SEP_CHAR:  cfg_q.separator_char   <= cfg_data_i;
        CFG_POINT:     cfg_q.point_char       <= cfg_data_i;
        CFG_FIRST:     cfg_q.first_group_size <= cfg_data_i[3:0];
        CFG_LATER:     cfg_q.later_group_size <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  fpdf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  fpdf_datapath #(
    .AMOUNT_WIDTH (AMOUNT_WIDTH),
    .MAX_DIGITS   (MAX_DIGITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .amount_high_i (in_if.amount_high),
    .amount_low_i  (in_if.amount_low),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_ready_i   (out_if.ready),
    .out_valid_o   (out_if.valid),
    .text_char_o   (out_if.text_char),
    .last_char_o   (out_if.last_char)
  );

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
module testbench;
  import fpdf_pkg::*;

  localparam int unsigned NUM_DIGITS = 39;
  localparam int unsigned TEXT_MAX   = 64;
  localparam int unsigned IDLE_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned ITEMS_PER_SETTING = 46;
  localparam logic [CfgIndexW-1:0] CFG_UNUSED = 3'd7;
  localparam logic [7:0] CHAR_COMMA = 8'h2c;
  localparam logic [7:0] CHAR_DOT   = 8'h2e;
  localparam logic [7:0] CHAR_UNDER = 8'h5f;
  localparam logic [7:0] CHAR_QUOTE = 8'h27;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_beat_t;

  // register bytes in index order: scale, precision, group enable,
  // separator, point, first group, later group
  typedef logic [7:0] reg_bytes_t [7];

  // expected text of accepted amounts, checked beat by beat
  class text_scoreboard;
    cfg_t       regs;
    text_beat_t pending[$];
    logic [7:0] txt [TEXT_MAX];
    int         txt_len;
    int         errors;
    int         beats;
    int         amounts;

    function new();
      regs = '{RST_SCALE, RST_PRECISION, RST_GROUP_EN, RST_SEP_CHAR, RST_POINT,
               RST_FIRST, RST_LATER};
    endfunction

    function void set_reg(logic [CfgIndexW-1:0] idx, logic [7:0] d);
      case (idx)
        CFG_SCALE:     regs.scale_exponent   = d[5:0];
        CFG_PRECISION: regs.precision        = d[5:0];
        CFG_GROUP_EN:  regs.group_enable     = d[0];
        CFG_SEP_CHAR:  regs.separator_char   = d;
        CFG_POINT:     regs.point_char       = d;
        CFG_FIRST:     regs.first_group_size = d[3:0];
        CFG_LATER:     regs.later_group_size = d[3:0];
        default: ;
      endcase
    endfunction

    function int clamp_group(logic [3:0] g);
      if (g < GROUP_MIN) return GROUP_MIN;
      if (g > GROUP_MAX) return GROUP_MAX;
      return g;
    endfunction

    // append one character to the text, capped at the text length
    function void put_char(logic [7:0] c);
      if (txt_len < TEXT_MAX) begin
        txt[txt_len] = c;
        txt_len++;
      end
    endfunction

    // build the text for one amount and queue it
    function void note_amount(logic [127:0] amt);
      logic [3:0]   dig [NUM_DIGITS];
      logic [127:0] v;
      text_beat_t   beat;
      int e, p, f, l, top, q;
      bit frac_nz, shown_nz, grouping, rest;
      v = amt;
      for (int i = 0; i < NUM_DIGITS; i++) begin
        dig[i] = 4'(v % 10);
        v = v / 10;
      end
      e = regs.scale_exponent;
      if (e > NUM_DIGITS - 1) e = NUM_DIGITS - 1;
      p = regs.precision;
      if (p > e) p = e;
      f = clamp_group(regs.first_group_size);
      l = clamp_group(regs.later_group_size);
      grouping = regs.group_enable && regs.separator_char != 0;
      frac_nz = 0;
      shown_nz = 0;
      txt_len = 0;
      for (int i = 0; i < e; i++) if (dig[i] != 0) frac_nz = 1;
      for (int k = 1; k <= p; k++) if (dig[e-k] != 0) shown_nz = 1;
      top = e;
      for (int i = NUM_DIGITS - 1; i > e; i--) begin
        if (dig[i] != 0) begin
          top = i;
          break;
        end
      end
      if (top == e && dig[e] == 0 && frac_nz && !shown_nz) begin
        // below the smallest shown unit
        put_char(CHAR_LESS);
        put_char(CHAR_SPACE);
        if (p > 0) begin
          put_char(CHAR_ZERO);
          put_char(regs.point_char);
          for (int k = 0; k < p - 1; k++) put_char(CHAR_ZERO);
        end
        put_char(CHAR_ONE);
      end else begin
        for (int i = top; i >= e; i--) begin
          q = i - e;
          put_char(CHAR_ZERO + 8'(dig[i]));
          if (grouping && q > 0 && q >= f && (q - f) % l == 0)
            put_char(regs.separator_char);
        end
        // truncated fraction, trailing zeros dropped
        if (p > 0 && frac_nz) begin
          put_char(regs.point_char);
          for (int k = 1; k <= p; k++) begin
            put_char(CHAR_ZERO + 8'(dig[e-k]));
            rest = 0;
            for (int i = e - k - 1; i >= 0; i--) if (dig[i] != 0) rest = 1;
            if (!rest) break;
          end
        end
      end
      for (int i = 0; i < txt_len; i++) begin
        beat.ch   = txt[i];
        beat.last = (i == txt_len - 1);
        pending.insert(pending.size(), beat);
      end
      amounts++;
    endfunction

    function void check_beat(logic [7:0] ch, logic last);
      text_beat_t exp_beat;
      beats++;
      if (pending.size() == 0) begin
        $error("unexpected beat: text_char %h last_char %b", ch, last);
        errors++;
        return;
      end
      exp_beat = pending.pop_front();
      if (ch !== exp_beat.ch) begin
        $error("text_char mismatch: expected %h actual %h", exp_beat.ch, ch);
        errors++;
      end
      if (last !== exp_beat.last) begin
        $error("last_char mismatch: expected %b actual %b", exp_beat.last, last);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIndexW-1:0] cfg_index_i;
  logic [7:0] cfg_data_i;

  fpdf_in_if  in_bus ();
  fpdf_out_if out_bus ();

  fixed_point_decimal_formatter_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_bus),
    .out_if      (out_bus),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  text_scoreboard sb = new();
  int  send_idle;
  int  recv_idle;
  bit  hold_req;
  int  hold_left;
  int  sent_count;
  int  quiet_cycles;
  int  setting_count;

  // clock
  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // output side: check beats, random stalls, long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) sb.check_beat(out_bus.text_char, out_bus.last_char);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // watchdog on cycles with no beat moving
  always @(posedge clk_i) begin
    if (rst_ni && !((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))) begin
      quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("timeout after %0d quiet cycles", quiet_cycles);
        $display("fixed_point_decimal_formatter_core verification failed");
        $finish;
      end
    end else begin
      quiet_cycles = 0;
    end
  end

  function automatic logic [127:0] pow10(int n);
    logic [127:0] r;
    r = 1;
    for (int i = 0; i < n; i++) r = r * 10;
    return r;
  endfunction

  function automatic logic [127:0] rand_amount();
    logic [127:0] r;
    r = {$urandom, $urandom, $urandom, $urandom};
    case ($urandom_range(4))
      0: return r;
      1: return $urandom;
      2: return {$urandom, $urandom} * pow10($urandom_range(38));
      3: return r % pow10($urandom_range(39)) * pow10($urandom_range(8));
      default: return pow10($urandom_range(38)) - $urandom_range(1);
    endcase
  endfunction

  // idle mix follows progress through the run
  task automatic pick_idle();
    if (sent_count < 157) begin
      send_idle = 17;
      recv_idle = 64;
    end else if (sent_count < 314) begin
      send_idle = 64;
      recv_idle = 17;
    end else begin
      send_idle = 0;
      recv_idle = 0;
    end
  endtask

  task automatic send_amount(logic [127:0] amt);
    pick_idle();
    if ($urandom_range(99) < send_idle) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle) @(posedge clk_i);
    end
    in_bus.valid       <= 1'b1;
    in_bus.amount_high <= amt[127:64];
    in_bus.amount_low  <= amt[63:0];
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    sb.note_amount(amt);
    sent_count++;
  endtask

  // stop offering and wait for every expected beat
  task automatic drain();
    in_bus.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIndexW-1:0] idx, logic [7:0] d);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    @(posedge clk_i);
    sb.set_reg(idx, d);
  endtask

  task automatic apply_setting(reg_bytes_t rv);
    write_reg(CFG_SCALE, rv[0]);
    write_reg(CFG_PRECISION, rv[1]);
    write_reg(CFG_GROUP_EN, rv[2]);
    write_reg(CFG_SEP_CHAR, rv[3]);
    write_reg(CFG_POINT, rv[4]);
    write_reg(CFG_FIRST, rv[5]);
    write_reg(CFG_LATER, rv[6]);
    write_reg(CFG_UNUSED, $urandom_range(255));
    cfg_we_i <= 1'b0;
    setting_count++;
  endtask

  reg_bytes_t settings [8];

  initial begin
    reg_bytes_t rv;
    in_bus.valid       <= 1'b0;
    in_bus.amount_high <= '0;
    in_bus.amount_low  <= '0;
    cfg_we_i    <= 1'b0;
    cfg_index_i <= CFG_SCALE;
    cfg_data_i  <= '0;
    rst_ni      <= 1'b0;
    send_idle = 17;
    recv_idle = 64;
    hold_req = 1'b0;
    hold_left = 0;
    settings[0] = '{8'd0, 8'd0, 8'd1, CHAR_COMMA, CHAR_DOT, 8'd3, 8'd3};
    settings[1] = '{8'd38, 8'd38, 8'd1, CHAR_UNDER, CHAR_COMMA, 8'd2, 8'd9};
    settings[2] = '{8'd255, 8'd255, 8'd0, CHAR_COMMA, CHAR_DOT, 8'd9, 8'd2};
    settings[3] = '{8'd18, 8'd6, 8'd1, 8'd0, CHAR_DOT, 8'd0, 8'd15};
    settings[4] = '{8'd6, 8'd63, 8'd255, 8'hff, 8'h00, 8'd1, 8'hff};
    settings[5] = '{8'd5, 8'd0, 8'd1, CHAR_DOT, CHAR_COMMA, 8'd2, 8'd3};
    settings[6] = '{8'd12, 8'd3, 8'd1, CHAR_QUOTE, CHAR_COMMA, 8'd4, 8'd2};
    settings[7] = '{8'd39, 8'd1, 8'd1, CHAR_COMMA, CHAR_DOT, 8'd3, 8'd4};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed amounts at the reset settings
    send_amount(0);
    send_amount(1);
    send_amount('1);
    send_amount({64'd0, 64'hffff_ffff_ffff_ffff});
    send_amount({64'hffff_ffff_ffff_ffff, 64'd0});
    send_amount(pow10(30));
    send_amount(pow10(30) - 1);
    send_amount(pow10(28));
    send_amount(pow10(28) - 1);
    send_amount(5 * pow10(27));
    send_amount(123456789 * pow10(30));
    send_amount(pow10(38));
    send_amount(pow10(38) - 1);
    send_amount(pow10(30) + pow10(29) + 7);
    for (int i = 0; i < ITEMS_PER_SETTING; i++) send_amount(rand_amount());
    drain();

    // hold the output off while amounts keep coming
    hold_req = 1'b1;
    for (int i = 0; i < 8; i++) send_amount(rand_amount());
    drain();

    for (int s = 0; s < 11; s++) begin
      if (s < 8) begin
        rv = settings[s];
      end else begin
        foreach (rv[j]) rv[j] = $urandom_range(255);
        rv[0] = $urandom_range(39);
        rv[1] = $urandom_range(39);
      end
      apply_setting(rv);
      send_amount(0);
      send_amount('1);
      send_amount(1);
      for (int i = 0; i < ITEMS_PER_SETTING - 12; i++) send_amount(rand_amount());
      drain();
    end

    $display("checked %0d amounts, %0d text beats over %0d register settings",
             sb.amounts, sb.beats, setting_count);
    $display("idle mixes: sender/receiver 17/64, 64/17 and none, plus long output hold-off");
    if (sb.errors == 0) begin
      $display("fixed_point_decimal_formatter_core verification clean");
    end else begin
      $display("fixed_point_decimal_formatter_core verification failed");
    end
    $finish;
  end

endmodule
